[rtl/core/bslrg_pkg.sv]
package bslrg_pkg;

    localparam logic [31:0] LFSR_TAPS = 32'h8C54_0001;
    localparam logic [31:0] LFSR_INIT = 32'h0246_8ACD;

    // One input beat as the core sees it.
    typedef struct packed {
        logic       active;
        logic       read_req;
        logic       seed_req;
        logic [7:0] data_byte;
    } item_t;

    // Fibonacci step: shift right, new MSB is the parity of the tapped bits.
    function automatic logic [31:0] lfsr_next(input logic [31:0] g);
        lfsr_next = {^(g & LFSR_TAPS), g[31:1]};
    endfunction

endpackage

[rtl/core/byte_serial_lfsr_random_generator.sv]
// Byte-serial pseudo-random generator on a 32-bit Fibonacci LFSR.
// Input channel (s_*): one beat per clock while s_ready is high, carrying
// active, read_req, seed_req and data_byte. Every accepted input beat yields
// exactly one result beat on the m_* channel carrying m_out_byte.
// Idle beat (active, no transfer running, no request): step the LFSR,
// latch it as the held result, return zero.
// seed_req starts a four-beat seed load, low byte first; the fourth beat
// loads the LFSR. read_req returns the held result over four beats, low
// byte first. seed_req wins when both are raised. active low restores the
// initial LFSR value and clears both byte counters.
// A result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless stalled; all work for a beat is a single update of
// the state registers feeding one output register.
// Stall: while a result waits on m_ready low, s_ready drops; s_ready follows
// m_ready combinationally once the output register is full.
// Reset (aresetn low, synchronous): LFSR to its initial value, seed and
// held result to zero, counters cleared, output register empty.
module byte_serial_lfsr_random_generator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_active,
    input  logic       s_read_req,
    input  logic       s_seed_req,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte
);
    import bslrg_pkg::*;

    item_t      item;
    logic       accept;
    logic [7:0] core_byte;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg;

    // Take a new beat whenever the output register is empty or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign item.active    = s_active;
    assign item.read_req  = s_read_req;
    assign item.seed_req  = s_seed_req;
    assign item.data_byte = s_data_byte;

    bslrg_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .item     (item),
        .out_byte (core_byte)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload register: hold while stalled, load on accept.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_byte_reg <= core_byte;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;

endmodule

[rtl/core/bslrg_core.sv]
module bslrg_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  bslrg_pkg::item_t     item,
    output logic [7:0]           out_byte
);
    import bslrg_pkg::*;

    logic [31:0] gen_reg,  gen_next;
    logic [31:0] seed_reg, seed_next;
    logic [31:0] hold_reg, hold_next;
    logic [1:0]  load_cnt_reg, load_cnt_next;
    logic [1:0]  emit_cnt_reg, emit_cnt_next;
    logic [31:0] seed_merged;

    // Drop the incoming byte into its lane of the assembly word.
    always_comb begin
        seed_merged = seed_reg;
        seed_merged[{load_cnt_reg, 3'b000} +: 8] = item.data_byte;
    end

    always_comb begin
        gen_next      = gen_reg;
        seed_next     = seed_reg;
        hold_next     = hold_reg;
        load_cnt_next = load_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        out_byte      = 8'h00;
        if (!item.active) begin
            load_cnt_next = 2'd0;
            emit_cnt_next = 2'd0;
            gen_next      = LFSR_INIT;
        end else if (emit_cnt_reg != 2'd0) begin
            out_byte      = hold_reg[{emit_cnt_reg, 3'b000} +: 8];
            emit_cnt_next = emit_cnt_reg + 2'd1;
        end else if (load_cnt_reg != 2'd0) begin
            seed_next     = seed_merged;
            load_cnt_next = load_cnt_reg + 2'd1;
            if (load_cnt_reg == 2'd3) begin
                gen_next = seed_merged;
            end
        end else if (item.seed_req) begin
            seed_next     = {24'h000000, item.data_byte};
            load_cnt_next = 2'd1;
        end else if (item.read_req) begin
            out_byte      = hold_reg[7:0];
            emit_cnt_next = 2'd1;
        end else begin
            gen_next  = lfsr_next(gen_reg);
            hold_next = gen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg      <= LFSR_INIT;
            seed_reg     <= 32'h0;
            hold_reg     <= 32'h0;
            load_cnt_reg <= 2'd0;
            emit_cnt_reg <= 2'd0;
        end else if (step) begin
            gen_reg      <= gen_next;
            seed_reg     <= seed_next;
            hold_reg     <= hold_next;
            load_cnt_reg <= load_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

endmodule

[rtl/core/bslrg_checker.sv]
module bslrg_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte
);

    // Output register is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // Every accepted input beat produces a result beat next cycle.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted beat gave no result");

    // A stalled result blocks new input beats.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_byte)))
        else $error("stalled result changed");

endmodule

bind byte_serial_lfsr_random_generator bslrg_checker u_bslrg_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte)
);
